>>> src/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg: shared types and constants for the MIDI byte stream parser
// Request structs for both channels, result kinds and status nibbles.
// ----------------------------------------------------------------------------
package mbsp_pkg;

  // Data bytes kept per sysex message; bytes past this cap are dropped.
  localparam int unsigned MAX_SYSEX   = 1024;
  localparam int unsigned SX_CNT_W    = 11;

  localparam logic [SX_CNT_W-1:0] SX_LIMIT = SX_CNT_W'(MAX_SYSEX);

  // Result kinds
  localparam logic [3:0] K_NOTE     = 4'd0;
  localparam logic [3:0] K_POLY     = 4'd1;
  localparam logic [3:0] K_CTRL     = 4'd2;
  localparam logic [3:0] K_PROG     = 4'd3;
  localparam logic [3:0] K_CPRES    = 4'd4;
  localparam logic [3:0] K_BEND     = 4'd5;
  localparam logic [3:0] K_SX_START = 4'd6;
  localparam logic [3:0] K_SX_DATA  = 4'd7;
  localparam logic [3:0] K_SX_END   = 4'd8;

  // Status nibbles and system bytes
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY     = 4'hA;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_CPRES    = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_NONE     = 4'h0;
  localparam logic [7:0] SYSEX_BEGIN = 8'hF0;
  localparam logic [7:0] SYSEX_STOP  = 8'hF7;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       out_of_range;
  } mbsp_in_t;

  typedef struct packed {
    logic [3:0]          msg_kind;
    logic [3:0]          channel;
    logic [6:0]          data_a;
    logic [13:0]         data_b;
    logic [SX_CNT_W-1:0] sysex_length;
  } mbsp_out_t;

endpackage

>>> src/midi_byte_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit: MIDI byte stream to decoded messages
// Top level: input request register, decoder, result register.
// ----------------------------------------------------------------------------
// Usage
//   byte channel  : one raw MIDI byte per request (byte_valid / byte_stall /
//                   byte_data). out_of_range drops the byte and clears any
//                   half-received channel message; sysex state is kept.
//   result channel: one decoded message per request (result_valid /
//                   result_stall / result_data). Channel status, the first of
//                   two data bytes, dropped sysex and swallowed pairs give none.
//   Path          : an accepted byte passes the input register, then the
//                   result register, before its result shows.
//   Throughput    : one byte per cycle when not stalled, set by the single
//                   decode pass between the registers; parser state updates in it.
//   Stall         : while result_stall holds a full result register, the held
//                   byte waits in the input register and byte_stall rises; a
//                   byte with no result still needs the result slot free.
//   Reset         : rst (sync, active high) empties both registers and clears
//                   status type, channel, pending data and sysex state.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit import mbsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  mbsp_in_t  byte_data,
  output logic      result_valid,
  input  logic      result_stall,
  output mbsp_out_t result_data
);

  logic      advance;   // result slot empty or draining this cycle
  logic      held;      // input register holds a byte
  logic      fire;      // decode consumes the held byte
  logic      hit;
  mbsp_in_t  item;
  mbsp_out_t res;

  assign advance = ~result_valid | ~result_stall;
  assign fire    = held & advance;

  mbsp_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .valid   (byte_valid),
    .stall   (byte_stall),
    .data    (byte_data),
    .advance (advance),
    .held    (held),
    .item    (item)
  );

  mbsp_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .hit  (hit),
    .res  (res)
  );

  // result register: refills or empties whenever the slot can advance
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire & hit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit) begin
      result_data <= res;
    end
  end

  // byte channel only backs up behind an occupied input register
  assert property (@(posedge clk) disable iff (rst) byte_stall |-> held)
    else $error("input stalled with empty register");

  // sysex length only on sysex end
  assert property (@(posedge clk) disable iff (rst)
      (result_valid && result_data.msg_kind != K_SX_END) |-> result_data.sysex_length == '0)
    else $error("length on non-end result");

  // sysex results carry channel 0
  assert property (@(posedge clk) disable iff (rst)
      (result_valid && (result_data.msg_kind == K_SX_START ||
       result_data.msg_kind == K_SX_DATA || result_data.msg_kind == K_SX_END))
      |-> result_data.channel == '0)
    else $error("sysex result with channel");

endmodule

>>> src/mbsp_in_stage.sv
// ----------------------------------------------------------------------------
// mbsp_in_stage: input request register
// Holds one accepted byte until the decoder can consume it.
// ----------------------------------------------------------------------------
module mbsp_in_stage import mbsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     valid,
  output logic     stall,
  input  mbsp_in_t data,
  input  logic     advance,   // decoder and result slot can take the held byte
  output logic     held,
  output mbsp_in_t item
);

  logic take;

  assign stall = held & ~advance;
  assign take  = valid & ~stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= take | (held & ~advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= data;
    end
  end

endmodule

>>> src/mbsp_decode.sv
// ----------------------------------------------------------------------------
// mbsp_decode: parser state and single-pass byte decode
// Updates status / sysex state and forms at most one result per byte.
// ----------------------------------------------------------------------------
module mbsp_decode import mbsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  mbsp_in_t  item,
  output logic      hit,
  output mbsp_out_t res
);

  logic                in_sysex, in_sysex_next;
  logic [SX_CNT_W-1:0] sysex_count, sysex_count_next;
  logic [3:0]          status_type, status_type_next;
  logic [3:0]          chan_reg, chan_reg_next;
  logic                data_ready, data_ready_next;
  logic [6:0]          first_data, first_data_next;

  logic [7:0] b;
  assign b = item.byte_value;

  always_comb begin
    in_sysex_next    = in_sysex;
    sysex_count_next = sysex_count;
    status_type_next = status_type;
    chan_reg_next    = chan_reg;
    data_ready_next  = data_ready;
    first_data_next  = first_data;
    hit              = 1'b0;
    res              = '0;

    if (item.out_of_range) begin
      status_type_next = ST_NONE;
      data_ready_next  = 1'b0;
    end else if (b[7]) begin
      if (b == SYSEX_BEGIN) begin
        in_sysex_next    = 1'b1;
        sysex_count_next = '0;
        hit              = 1'b1;
        res.msg_kind     = K_SX_START;
      end else if (b == SYSEX_STOP) begin
        hit              = in_sysex;
        res.msg_kind     = K_SX_END;
        res.sysex_length = sysex_count;
        in_sysex_next    = 1'b0;
        sysex_count_next = '0;
      end else begin
        status_type_next = b[7:4];
        chan_reg_next    = b[3:0];
        data_ready_next  = (b[7:4] == ST_PROG) || (b[7:4] == ST_CPRES);
      end
    end else if (in_sysex) begin
      // bytes past the cap are dropped silently
      if (sysex_count < SX_LIMIT) begin
        sysex_count_next = sysex_count + 1'b1;
        hit              = 1'b1;
        res.msg_kind     = K_SX_DATA;
        res.data_a       = b[6:0];
      end
    end else if (!data_ready) begin
      first_data_next = b[6:0];
      data_ready_next = 1'b1;
    end else begin
      status_type_next = ST_NONE;
      data_ready_next  = 1'b0;
      res.channel      = chan_reg;
      hit              = 1'b1;
      unique case (status_type)
        ST_NOTE_OFF: begin
          res.msg_kind = K_NOTE;
          res.data_a   = first_data;
        end
        ST_NOTE_ON: begin
          res.msg_kind = K_NOTE;
          res.data_a   = first_data;
          res.data_b   = {7'd0, b[6:0]};
        end
        ST_POLY: begin
          res.msg_kind = K_POLY;
          res.data_a   = first_data;
          res.data_b   = {7'd0, b[6:0]};
        end
        ST_CTRL: begin
          res.msg_kind = K_CTRL;
          res.data_a   = first_data;
          res.data_b   = {7'd0, b[6:0]};
        end
        ST_PROG: begin
          res.msg_kind = K_PROG;
          res.data_b   = {7'd0, b[6:0]};
        end
        ST_CPRES: begin
          res.msg_kind = K_CPRES;
          res.data_b   = {7'd0, b[6:0]};
        end
        ST_BEND: begin
          res.msg_kind = K_BEND;
          res.data_b   = {b[6:0], first_data};
        end
        default: begin
          // system or cleared type: pair swallowed
          hit = 1'b0;
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex    <= 1'b0;
      sysex_count <= '0;
      status_type <= ST_NONE;
      chan_reg    <= '0;
      data_ready  <= 1'b0;
      first_data  <= '0;
    end else if (fire) begin
      in_sysex    <= in_sysex_next;
      sysex_count <= sysex_count_next;
      status_type <= status_type_next;
      chan_reg    <= chan_reg_next;
      data_ready  <= data_ready_next;
      first_data  <= first_data_next;
    end
  end

  // count never runs past the cap
  assert property (@(posedge clk) disable iff (rst) sysex_count <= SX_LIMIT)
    else $error("sysex count above cap");

  // count is cleared whenever sysex is not open
  assert property (@(posedge clk) disable iff (rst) !in_sysex |-> sysex_count == '0)
    else $error("sysex count nonzero outside sysex");

  // a consumed out-of-range byte never produces a result
  assert property (@(posedge clk) disable iff (rst)
      (fire && item.out_of_range) |-> !hit)
    else $error("result from out-of-range byte");

endmodule
